[hw/rtl/mdf_pkg.sv]
// ----------------------------------------------------------------------------
// mdf_pkg
// shared constants, codes and the command struct of the modular divider
// ----------------------------------------------------------------------------
package mdf_pkg;

  typedef logic [29:0] res_t;

  // prime modulus and fermat exponent
  localparam res_t Modulus  = 30'd998244353;
  localparam res_t Exponent = Modulus - 30'd2;
  localparam logic [4:0] LastBit = 5'd29;

  // barrett constant floor(2^60 / modulus), below 2^31 for a 30-bit modulus
  localparam logic [63:0] MuFull    = 64'h1000_0000_0000_0000 / {34'd0, Modulus};
  localparam logic [30:0] BarrettMu = MuFull[30:0];

  // which modular product is running
  localparam logic [1:0] OP_SQ  = 2'd0;  // sq  <= sq * sq
  localparam logic [1:0] OP_ACC = 2'd1;  // acc <= acc * sq
  localparam logic [1:0] OP_FIN = 2'd2;  // quotient <= num * acc

  // steps of one modular product on the shared multiplier
  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_MUL  = 3'd1;  // full product
  localparam logic [2:0] STEP_QUO  = 3'd2;  // barrett quotient estimate
  localparam logic [2:0] STEP_QM   = 3'd3;  // estimate times modulus
  localparam logic [2:0] STEP_SUB  = 3'd4;  // raw remainder
  localparam logic [2:0] STEP_FIX  = 3'd5;  // final correction and write back

  typedef struct packed {
    logic       load;
    logic [1:0] op;
    logic [2:0] step;
  } cmd_t;

endpackage

[hw/rtl/mdf_datapath.sv]
// ----------------------------------------------------------------------------
// mdf_datapath
// operand registers, shared multiplier and barrett reduction
// ----------------------------------------------------------------------------
module mdf_datapath
  import mdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  res_t        dividend_i,
  input  res_t        divisor_i,
  output res_t        quotient_o
);

  res_t        num_q, num_d;
  res_t        acc_q, acc_d;
  res_t        sq_q, sq_d;
  res_t        quo_q, quo_d;
  logic [59:0] prod_q, prod_d;
  logic [30:0] est_q, est_d;
  logic [31:0] qm_q, qm_d;
  logic [31:0] rem_q, rem_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [30:0] red_num, red_den;
  logic [32:0] sub1, sub2;
  res_t        fixed;
  res_t        opa, opb;

  // inputs are below 2^30 < 2 * modulus, one subtract reduces them
  assign red_num = {1'b0, dividend_i} - {1'b0, Modulus};
  assign red_den = {1'b0, divisor_i} - {1'b0, Modulus};

  always_comb begin
    unique case (cmd_i.op)
      OP_SQ:   begin opa = sq_q;  opb = sq_q; end
      OP_ACC:  begin opa = acc_q; opb = sq_q; end
      OP_FIN:  begin opa = num_q; opb = acc_q; end
      default: begin opa = sq_q;  opb = sq_q; end
    endcase
  end

  // one shared multiplier, operands picked by step
  always_comb begin
    unique case (cmd_i.step)
      STEP_QUO: begin
        mul_a = {1'b0, prod_q[59:29]};
        mul_b = {1'b0, BarrettMu};
      end
      STEP_QM: begin
        mul_a = {1'b0, est_q};
        mul_b = {2'b0, Modulus};
      end
      default: begin
        mul_a = {2'b0, opa};
        mul_b = {2'b0, opb};
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // barrett remainder is below 3 * modulus
  assign sub1 = {1'b0, rem_q} - {3'b0, Modulus};
  assign sub2 = {1'b0, rem_q} - {2'b0, Modulus, 1'b0};

  always_comb begin
    if (!sub2[32]) begin
      fixed = sub2[29:0];
    end else if (!sub1[32]) begin
      fixed = sub1[29:0];
    end else begin
      fixed = rem_q[29:0];
    end
  end

  always_comb begin
    num_d  = num_q;
    acc_d  = acc_q;
    sq_d   = sq_q;
    quo_d  = quo_q;
    prod_d = prod_q;
    est_d  = est_q;
    qm_d   = qm_q;
    rem_d  = rem_q;
    if (cmd_i.load) begin
      num_d = red_num[30] ? dividend_i : red_num[29:0];
      sq_d  = red_den[30] ? divisor_i  : red_den[29:0];
      acc_d = 30'd1;
    end
    unique case (cmd_i.step)
      STEP_MUL: prod_d = mul_p[59:0];
      STEP_QUO: est_d  = mul_p[61:31];
      STEP_QM:  qm_d   = mul_p[31:0];
      STEP_SUB: rem_d  = prod_q[31:0] - qm_q;
      STEP_FIX: begin
        unique case (cmd_i.op)
          OP_SQ:   sq_d  = fixed;
          OP_ACC:  acc_d = fixed;
          OP_FIN:  quo_d = fixed;
          default: sq_d  = sq_q;
        endcase
      end
      default: begin
        prod_d = prod_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      acc_q  <= '0;
      sq_q   <= '0;
      quo_q  <= '0;
      prod_q <= '0;
      est_q  <= '0;
      qm_q   <= '0;
      rem_q  <= '0;
    end else begin
      num_q  <= num_d;
      acc_q  <= acc_d;
      sq_q   <= sq_d;
      quo_q  <= quo_d;
      prod_q <= prod_d;
      est_q  <= est_d;
      qm_q   <= qm_d;
      rem_q  <= rem_d;
    end
  end

  assign quotient_o = quo_q;

endmodule

[hw/rtl/mdf_ctrl.sv]
// ----------------------------------------------------------------------------
// mdf_ctrl
// sequencer for square-and-multiply and the request and result handshakes
// ----------------------------------------------------------------------------
module mdf_ctrl
  import mdf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] op_q, op_d;
  logic [4:0] bit_q, bit_d;
  logic       valid_q, valid_d;
  logic       accept, stall;
  logic [4:0] bit_nxt;

  // product to run when a new exponent bit starts
  function automatic logic [1:0] pick_op(input logic [4:0] idx);
    logic [1:0] op;
    if (Exponent[idx]) begin
      op = OP_ACC;
    end else if (idx == LastBit) begin
      op = OP_FIN;
    end else begin
      op = OP_SQ;
    end
    return op;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // final write waits while the previous result is still held
  assign stall      = (step_q == STEP_FIX) && (op_q == OP_FIN) && valid_q && !out_ready_i;
  assign bit_nxt    = bit_q + 5'd1;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    op_d    = op_q;
    bit_d   = bit_q;
    valid_d = valid_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          step_d  = STEP_MUL;
          bit_d   = 5'd0;
          op_d    = pick_op(5'd0);
        end
      end
      ST_RUN: begin
        if (step_q != STEP_FIX) begin
          step_d = step_q + 3'd1;
        end else if (!stall) begin
          step_d = STEP_MUL;
          unique case (op_q)
            OP_ACC: op_d = (bit_q == LastBit) ? OP_FIN : OP_SQ;
            OP_SQ: begin
              bit_d = bit_nxt;
              op_d  = pick_op(bit_nxt);
            end
            default: begin
              state_d = ST_IDLE;
              step_d  = STEP_IDLE;
              valid_d = 1'b1;
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_IDLE;
      op_q    <= OP_SQ;
      bit_q   <= 5'd0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      op_q    <= op_d;
      bit_q   <= bit_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.op    = op_q;
  assign cmd_o.step  = ((state_q == ST_RUN) && !stall) ? step_q : STEP_IDLE;

endmodule

[hw/rtl/modular_division_fermat.sv]
// ----------------------------------------------------------------------------
// modular_division_fermat
// sequence: each request runs 58 modular products (29 squarings,
//   28 exponent-bit multiplies, one final multiply by the dividend) in turn
//   on one shared 32x32 multiplier
// requests: a new one is taken only once the previous products are done;
//   the final write also waits while an earlier result is still held
// reset: asynchronous active-low, clears the sequencer, output valid and datapath
// ----------------------------------------------------------------------------
module modular_division_fermat
  import mdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [29:0] dividend_i,
  input  logic [29:0] divisor_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [29:0] quotient_o
);

  // quotient = dividend * divisor^(modulus - 2) mod modulus
  // exponent bits are scanned from the lsb; each bit multiplies the running
  // product by the current square when set, then squares (not after the top bit)
  // each modular product: full product, barrett estimate, estimate * modulus,
  // subtract, then at most two corrective subtracts in one select
  // a zero divisor falls through naturally to a zero quotient

  cmd_t cmd;

  // sequencer: exponent bit counter, product step and the result handshake
  mdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // operands, multiplier and reduction; the result register stays apart from
  // the working registers so a new request can start while it waits
  mdf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .quotient_o (quotient_o)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the fermat modular divider against a square-and-multiply predictor;
// directed corner requests, then random ones under changing handshake stalls
// ----------------------------------------------------------------------------
module tb_top
  import mdf_pkg::*;
();

  // the block handles one request at a time
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_REQS  = 500;
  localparam res_t        AllOnes      = 30'h3FFF_FFFF;

  typedef struct packed {
    res_t dividend;
    res_t divisor;
  } div_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request side
  logic req_valid    = 1'b0;
  logic req_ready;
  res_t req_dividend = '0;
  res_t req_divisor  = '0;

  // result side
  logic res_valid;
  logic res_ready    = 1'b0;
  res_t res_quotient;

  div_req_t    pending_reqs[$];
  res_t        quotient_exp[$];
  int unsigned total_reqs;
  int unsigned accepted_reqs = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  modular_division_fermat dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .dividend_i (req_dividend),
    .divisor_i  (req_divisor),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .quotient_o (res_quotient)
  );

  always #5 clk_i = ~clk_i;

  // dividend * divisor^(p-2) mod p, exponent bits scanned from the lsb
  function automatic res_t fermat_quotient(res_t num, res_t den);
    longint unsigned prime;
    longint unsigned n;
    longint unsigned sq;
    longint unsigned acc;
    longint unsigned e;
    prime = longint'(Modulus);
    n     = longint'(num) % prime;
    sq    = longint'(den) % prime;
    acc   = 1;
    e     = prime - 2;
    while (e != 0) begin
      if (e[0]) begin
        acc = (acc * sq) % prime;
      end
      sq = (sq * sq) % prime;
      e  = e >> 1;
    end
    return res_t'((n * acc) % prime);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // stall profile follows progress: receiver-heavy, sender-heavy, then none
  function automatic int unsigned sender_idle_pct();
    if (accepted_reqs < total_reqs / 3) begin
      return 22;
    end else if (accepted_reqs < 2 * total_reqs / 3) begin
      return 47;
    end
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (accepted_reqs < total_reqs / 3) begin
      return 47;
    end else if (accepted_reqs < 2 * total_reqs / 3) begin
      return 22;
    end
    return 0;
  endfunction

  // operand mix: in-range residues, raw 30-bit patterns, and values near
  // zero, just under the modulus and at or just over it
  function automatic res_t rand_operand();
    case ($urandom_range(9))
      0, 1, 2, 3: return res_t'($urandom_range(int'(Modulus) - 1));
      4, 5, 6:    return res_t'($urandom()) & AllOnes;
      7:          return res_t'($urandom_range(16));
      8:          return Modulus - 30'd1 - res_t'($urandom_range(16));
      default:    return Modulus + res_t'($urandom_range(16));
    endcase
  endfunction

  task automatic add_req(res_t dividend, res_t divisor);
    div_req_t r;
    r.dividend = dividend;
    r.divisor  = divisor;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // driver: holds each request until accepted, records its expected quotient
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid    <= 1'b0;
      req_dividend <= '0;
      req_divisor  <= '0;
    end else begin : drive
      logic     nxt_valid;
      div_req_t r;
      nxt_valid = req_valid;
      if (req_valid && req_ready) begin
        quotient_exp.insert(quotient_exp.size(),
                            fermat_quotient(req_dividend, req_divisor));
        accepted_reqs <= accepted_reqs + 1;
        nxt_valid = 1'b0;
      end
      // a new request goes out only once the previous one has been taken
      if (!nxt_valid && pending_reqs.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct()) begin
        r = pending_reqs.pop_front();
        req_dividend <= r.dividend;
        req_divisor  <= r.divisor;
        nxt_valid = 1'b1;
      end
      req_valid <= nxt_valid;
    end
  end

  // monitor: compares each result with the oldest expected quotient
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin : watch
      res_t want;
      if (res_valid && res_ready) begin
        if (quotient_exp.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request outstanding",
                                    res_quotient));
        end else begin
          want = quotient_exp.pop_front();
          if (res_quotient !== want) begin
            report_mismatch($sformatf("quotient %0d, expected %0d",
                                      res_quotient, want));
          end
        end
      end
      res_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // operand extremes and bit-alternating patterns
    add_req(30'd0, 30'd1);
    add_req(30'd1, 30'd1);
    add_req(30'd5, 30'd3);
    add_req(Modulus - 30'd1, Modulus - 30'd1);
    add_req(Modulus - 30'd1, 30'd1);
    add_req(30'd1, Modulus - 30'd1);
    add_req(Modulus - 30'd1, 30'd2);
    add_req(30'd2, Modulus - 30'd1);
    add_req(30'h2AAA_AAAA, 30'h1555_5555);
    add_req(30'h1555_5555, 30'h2AAA_AAAA);
    // zero divisor, literally and as a multiple of the modulus
    add_req(30'd0, 30'd0);
    add_req(30'd1, 30'd0);
    add_req(AllOnes, 30'd0);
    add_req(30'd7, Modulus);
    // operands at or above the modulus get reduced first
    add_req(Modulus, 30'd5);
    add_req(Modulus + 30'd1, Modulus + 30'd1);
    add_req(AllOnes, AllOnes);
    add_req(AllOnes, 30'd1);
    add_req(30'd12345, AllOnes);
    add_req(Modulus - 30'd2, Modulus + 30'd2);
    repeat (RANDOM_REQS) begin
      add_req(rand_operand(), rand_operand());
    end
    total_reqs = pending_reqs.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything sent, accepted and answered
    while (pending_reqs.size() != 0 || req_valid || quotient_exp.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (quotient_exp.size() != 0) begin
      report_mismatch($sformatf("%0d quotients never arrived", quotient_exp.size()));
    end

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
